>>> hw/rtl/tdpt_pkg.sv
`timescale 1ns / 1ps

package tdpt_pkg;

   // Default width of the number under test.
   localparam int DEFAULT_NUMBER_WIDTH = 32;

   // First odd divisor tried, and the stride between odd divisors.
   localparam int FIRST_DIVISOR = 3;
   localparam int DIVISOR_STEP  = 2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture a new request and set the divisor to its first value
      logic start;    // begin a division of the number by the current divisor
      logic step;     // one restoring division step
      logic advance;  // move to the next odd divisor
   } tdpt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic below_two;   // number is 0 or 1
      logic even;        // number is even
      logic equals_two;  // number is exactly 2
      logic div_last;    // this cycle performs the last division step
      logic bound_fail;  // divisor exceeds quotient: no further divisor can divide
      logic rem_zero;    // the divisor divides the number exactly
   } tdpt_status_type;

endpackage

>>> hw/rtl/tdpt_datapath.sv
`timescale 1ns / 1ps

module tdpt_datapath
   import tdpt_pkg::*;
#(
   parameter int NUMBER_WIDTH = DEFAULT_NUMBER_WIDTH
) (
   input  logic                    clock,
   input  logic [NUMBER_WIDTH-1:0] candidate,
   input  tdpt_cmd_type            cmd,
   output tdpt_status_type         status
);

   localparam int COUNT_WIDTH = $clog2(NUMBER_WIDTH);

   logic [NUMBER_WIDTH-1:0] number_ff, number_in;
   logic [NUMBER_WIDTH-1:0] divisor_ff, divisor_in;
   logic [NUMBER_WIDTH-1:0] quotient_ff, quotient_in;
   logic [NUMBER_WIDTH-1:0] remainder_ff, remainder_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;

   logic [NUMBER_WIDTH:0]   trial;
   logic [NUMBER_WIDTH:0]   difference;
   logic                    fits;

   // Restoring division: shift the next numerator bit into the partial
   // remainder and subtract the divisor when it fits.
   assign trial      = {remainder_ff, quotient_ff[NUMBER_WIDTH-1]};
   assign difference = trial - {1'b0, divisor_ff};
   assign fits       = ~difference[NUMBER_WIDTH];

   always_comb begin
      number_in    = number_ff;
      divisor_in   = divisor_ff;
      quotient_in  = quotient_ff;
      remainder_in = remainder_ff;
      count_in     = count_ff;
      if (cmd.load) begin
         number_in  = candidate;
         divisor_in = NUMBER_WIDTH'(FIRST_DIVISOR);
      end
      if (cmd.advance) begin
         divisor_in = divisor_ff + NUMBER_WIDTH'(DIVISOR_STEP);
      end
      if (cmd.start) begin
         quotient_in  = number_ff;
         remainder_in = '0;
         count_in     = '0;
      end else if (cmd.step) begin
         quotient_in  = {quotient_ff[NUMBER_WIDTH-2:0], fits};
         remainder_in = fits ? difference[NUMBER_WIDTH-1:0] : trial[NUMBER_WIDTH-1:0];
         count_in     = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      number_ff    <= number_in;
      divisor_ff   <= divisor_in;
      quotient_ff  <= quotient_in;
      remainder_ff <= remainder_in;
      count_ff     <= count_in;
   end

   always_comb begin
      status.below_two  = (number_ff[NUMBER_WIDTH-1:1] == '0);
      status.even       = ~number_ff[0];
      status.equals_two = (number_ff == NUMBER_WIDTH'(2));
      status.div_last   = (count_ff == COUNT_WIDTH'(NUMBER_WIDTH - 1));
      status.bound_fail = (divisor_ff > quotient_ff);
      status.rem_zero   = (remainder_ff == '0);
   end

endmodule

>>> hw/rtl/tdpt_ctrl.sv
`timescale 1ns / 1ps

module tdpt_ctrl
   import tdpt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_is_prime,
   output tdpt_cmd_type    cmd,
   input  tdpt_status_type status
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CLASSIFY = 3'd1;
   localparam logic [2:0] ST_DIVIDE   = 3'd2;
   localparam logic [2:0] ST_DECIDE   = 3'd3;
   localparam logic [2:0] ST_DONE     = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       verdict_ff, verdict_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_is_prime_ff, rsp_is_prime_in;
   logic       publish;

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // The finished verdict moves to the output register as soon as it is free.
   assign publish = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      verdict_in  = verdict_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (status.below_two) begin
               verdict_in = 1'b0;
               state_in   = ST_DONE;
            end else if (status.even) begin
               verdict_in = status.equals_two;
               state_in   = ST_DONE;
            end else begin
               cmd.start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.bound_fail) begin
               verdict_in = 1'b1;
               state_in   = ST_DONE;
            end else if (status.rem_zero) begin
               verdict_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               cmd.start   = 1'b1;
               state_in    = ST_DIVIDE;
            end
         end
         ST_DONE: begin
            if (publish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_is_prime_in = rsp_is_prime_ff;
      if (publish) begin
         rsp_valid_in    = 1'b1;
         rsp_is_prime_in = verdict_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      verdict_ff      <= verdict_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

endmodule

>>> hw/rtl/trial_division_prime_test.sv
`timescale 1ns / 1ps

// Trial-division primality test. Each request carries one unsigned number;
// the single response says whether it is prime (0 and 1 are not prime, 2 is,
// other even numbers are not). Odd divisors 3, 5, 7 and so on are tried
// until one divides exactly or the divisor exceeds the quotient. Every
// divisor costs one pass of a shared bit-serial restoring divider followed
// by a decision state; an even number or one below two is decided without
// any division. For a 32-bit prime near the top of the range about 32768
// divisors are tried. One number is worked on at a time; a finished
// response waits in an output register, and the next request is taken
// meanwhile.

module trial_division_prime_test
   import tdpt_pkg::*;
#(
   parameter int NUMBER_WIDTH = DEFAULT_NUMBER_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [NUMBER_WIDTH-1:0] req_candidate,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_is_prime
);

   tdpt_cmd_type    cmd;
   tdpt_status_type status;

   tdpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_prime (rsp_is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   tdpt_datapath #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .candidate (req_candidate),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
